>>> design/kbrt_pkg.sv
package kbrt_pkg;

    localparam int BUCKET_SIZE = 8;
    localparam int NUM_BUCKETS = 160;
    localparam int NUM_SLOTS   = NUM_BUCKETS * BUCKET_SIZE;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int LADDR_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W       = $clog2(BUCKET_SIZE + 1);
    localparam int SLOT_W      = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
    localparam int MAX_OUT     = 64;
    localparam int LAST_BKT    = NUM_BUCKETS - 1;
    localparam int SPLIT_BKT   = 80;
    localparam int ID_W        = 160;
    localparam int TS_W        = 48;
    localparam int TOTAL_W     = 11;
    localparam int MC_W        = 7;
    localparam int OP_W        = 3;
    localparam int CHUNK_W     = 32;
    localparam int NUM_CHUNKS  = ID_W / CHUNK_W;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 64;
    localparam int CQ_DEPTH    = 2;
    localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);

    localparam logic [1:0] REG_OWN_HIGH = 2'd0;
    localparam logic [1:0] REG_OWN_MID  = 2'd1;
    localparam logic [1:0] REG_OWN_LOW  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE   = 3'd0,
        OP_MARK_BAD = 3'd1,
        OP_FIND     = 3'd2,
        OP_REFRESH  = 3'd3,
        OP_COUNT    = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_ADDED        = 4'd0,
        ST_UPDATED      = 4'd1,
        ST_PENDING      = 4'd2,
        ST_QUESTIONABLE = 4'd3,
        ST_REMOVED      = 4'd4,
        ST_NOT_FOUND    = 4'd5,
        ST_PEER         = 4'd6,
        ST_NONE         = 4'd7,
        ST_COUNT        = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_META,
        S_SRCH,
        S_DECIDE,
        S_SHIFT,
        S_DROP,
        S_PROM,
        S_FMETA,
        S_FDATA,
        S_FEND,
        S_RSCAN,
        S_RSEL,
        S_RSRCH,
        S_RDONE,
        S_OUT
    } t_bstate;

    typedef struct packed {
        logic [31:0] id_high;
        logic [63:0] id_mid;
        logic [63:0] id_low;
        logic [31:0] address;
        logic [15:0] port;
    } t_peer;

    typedef struct packed {
        t_peer            peer;
        logic [TS_W-1:0]  seen;
        logic             questionable;
    } t_live;

    typedef struct packed {
        t_peer            peer;
        logic [TS_W-1:0]  seen;
    } t_wait;

    typedef struct packed {
        logic [CNT_W-1:0]  fill;
        logic [TS_W-1:0]   touched;
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  wfill;
    } t_meta;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BKT_W-1:0] bucket;
        t_peer            peer;
        logic [MC_W-1:0]  mc;
        logic [TS_W-1:0]  now;
    } t_cmd;

    typedef struct packed {
        t_status             status;
        t_peer               peer;
        logic [TOTAL_W-1:0]  total;
        logic                changed;
        logic                last;
    } t_res;

    function automatic logic [4:0] lead32(logic [CHUNK_W-1:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            if (x[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic logic [LADDR_W-1:0] slot_addr(logic [BKT_W-1:0] b,
                                                     logic [CNT_W-1:0] s);
        return LADDR_W'(b) * LADDR_W'(BUCKET_SIZE) + LADDR_W'(s);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_wrap(logic [CNT_W:0] x);
        logic [CNT_W:0] r;
        r = (x >= (CNT_W+1)'(BUCKET_SIZE)) ? x - (CNT_W+1)'(BUCKET_SIZE) : x;
        return r[SLOT_W-1:0];
    endfunction

    function automatic t_res res_plain(t_status st, logic chg);
        t_res r;
        r = '0;
        r.status  = st;
        r.changed = chg;
        r.last    = 1'b1;
        return r;
    endfunction

    function automatic t_res res_peer(t_peer p, logic lst);
        t_res r;
        r = '0;
        r.status = ST_PEER;
        r.peer   = p;
        r.last   = lst;
        return r;
    endfunction

endpackage

>>> design/kbucket_routing_table.sv
// the back end handles one transaction at a time; the front end encodes each id
// by a 32-bit chunk scan of the id distance, top chunk first, into a bucket index
// bucket search and compaction run one slot per cycle through the live memory read port
// reset: synchronous, clears control, queues, counts and bucket metadata valid bits
module kbucket_routing_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [2:0]                    i_operation,
    input  logic [31:0]                   i_peer_id_high,
    input  logic [63:0]                   i_peer_id_mid,
    input  logic [63:0]                   i_peer_id_low,
    input  logic [31:0]                   i_peer_address,
    input  logic [15:0]                   i_peer_port,
    input  logic [6:0]                    i_max_count,
    input  logic [47:0]                   i_now,
    output logic                          empty,
    input  logic                          pop,
    output logic [3:0]                    o_status,
    output logic [31:0]                   o_out_id_high,
    output logic [63:0]                   o_out_id_mid,
    output logic [63:0]                   o_out_id_low,
    output logic [31:0]                   o_out_address,
    output logic [15:0]                   o_out_port,
    output logic [10:0]                   o_total_peers,
    output logic                          o_changed,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kbrt_pkg::PADDR_W-1:0]  paddr,
    input  logic [kbrt_pkg::PDATA_W-1:0]  pwdata,
    output logic [kbrt_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import kbrt_pkg::*;

    logic [31:0] r_own_high;
    logic [63:0] r_own_mid;
    logic [63:0] r_own_low;

    logic  cfg_we;
    t_peer in_peer;
    logic  cmd_valid;
    t_cmd  cmd;
    logic  cmd_pop;
    logic  oq_push;
    t_res  oq_data;
    logic  oq_full;
    t_res  oq_head;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_high <= '0;
            r_own_mid  <= '0;
            r_own_low  <= '0;
        end else if (cfg_we) begin
            case (paddr[4:3])
                REG_OWN_HIGH: r_own_high <= pwdata[31:0];
                REG_OWN_MID:  r_own_mid  <= pwdata;
                REG_OWN_LOW:  r_own_low  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_OWN_HIGH: prdata = {32'd0, r_own_high};
            REG_OWN_MID:  prdata = r_own_mid;
            REG_OWN_LOW:  prdata = r_own_low;
            default:      prdata = '0;
        endcase
    end

    assign in_peer.id_high = i_peer_id_high;
    assign in_peer.id_mid  = i_peer_id_mid;
    assign in_peer.id_low  = i_peer_id_low;
    assign in_peer.address = i_peer_address;
    assign in_peer.port    = i_peer_port;

    kbrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_operation),
        .i_peer      (in_peer),
        .i_mc        (i_max_count),
        .i_now       (i_now),
        .i_own_id    ({r_own_high, r_own_mid, r_own_low}),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    kbrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_oq_push   (oq_push),
        .o_oq_data   (oq_data),
        .i_oq_full   (oq_full)
    );

    kbrt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_data),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (oq_head)
    );

    assign o_status      = oq_head.status;
    assign o_out_id_high = oq_head.peer.id_high;
    assign o_out_id_mid  = oq_head.peer.id_mid;
    assign o_out_id_low  = oq_head.peer.id_low;
    assign o_out_address = oq_head.peer.address;
    assign o_out_port    = oq_head.peer.port;
    assign o_total_peers = oq_head.total;
    assign o_changed     = oq_head.changed;
    assign o_last        = oq_head.last;

endmodule

>>> design/kbrt_front.sv
module kbrt_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [kbrt_pkg::OP_W-1:0] i_op,
    input  kbrt_pkg::t_peer        i_peer,
    input  logic [kbrt_pkg::MC_W-1:0] i_mc,
    input  logic [kbrt_pkg::TS_W-1:0] i_now,
    input  logic [kbrt_pkg::ID_W-1:0] i_own_id,
    output logic                   o_cmd_valid,
    output kbrt_pkg::t_cmd         o_cmd,
    input  logic                   i_cmd_pop
);
    import kbrt_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    t_cmd                   r_item;
    t_cmd                   r_q [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]    r_qwr;
    logic [CQ_PTR_W-1:0]    r_qrd;
    logic [CQ_PTR_W:0]      r_qcnt;

    logic [ID_W-1:0]    xid;
    logic [CHUNK_W-1:0] chunk;
    logic               accept;
    logic               qpush;
    logic               qpop;

    assign xid    = {r_item.peer.id_high, r_item.peer.id_mid, r_item.peer.id_low} ^ i_own_id;
    assign chunk  = xid[CHUNK_W*r_chunk +: CHUNK_W];
    assign accept = i_push && !r_busy;
    assign qpush  = r_busy && r_done && (r_qcnt != (CQ_PTR_W+1)'(CQ_DEPTH));
    assign qpop   = i_cmd_pop && (r_qcnt != '0);

    assign o_full      = r_busy;
    assign o_cmd_valid = (r_qcnt != '0);
    assign o_cmd       = r_q[r_qrd];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_chunk <= '0;
            r_qwr   <= '0;
            r_qrd   <= '0;
            r_qcnt  <= '0;
        end else begin
            if (accept) begin
                r_busy  <= 1'b1;
                r_done  <= 1'b0;
                r_chunk <= CHUNK_IDX_W'(NUM_CHUNKS - 1);
            end else if (r_busy && !r_done) begin
                if (chunk != '0 || r_chunk == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_chunk <= r_chunk - 1'b1;
                end
            end else if (qpush) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
            end
            if (qpush) r_qwr <= r_qwr + 1'b1;
            if (qpop)  r_qrd <= r_qrd + 1'b1;
            if (qpush && !qpop) begin
                r_qcnt <= r_qcnt + 1'b1;
            end else if (qpop && !qpush) begin
                r_qcnt <= r_qcnt - 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op     <= i_op;
            r_item.bucket <= '0;
            r_item.peer   <= i_peer;
            r_item.mc     <= i_mc;
            r_item.now    <= i_now;
        end else if (r_busy && !r_done) begin
            if (chunk != '0) begin
                r_item.bucket <= BKT_W'(r_chunk) * BKT_W'(CHUNK_W) + BKT_W'(lead32(chunk));
            end else begin
                r_item.bucket <= '0;
            end
        end
        if (qpush) r_q[r_qwr] <= r_item;
    end

endmodule

>>> design/kbrt_back.sv
module kbrt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  kbrt_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_oq_push,
    output kbrt_pkg::t_res  o_oq_data,
    input  logic            i_oq_full
);
    import kbrt_pkg::*;

    t_live r_live_mem [NUM_SLOTS];
    t_wait r_wait_mem [NUM_SLOTS];
    t_meta r_meta_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_meta_vld;

    t_live r_live_rd;
    t_wait r_wait_rd;
    t_meta r_meta_rd;
    logic  r_mvld_rd;

    t_bstate          r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    t_meta            r_meta, n_meta;
    t_live            r_ent, n_ent;
    t_live            r_got, n_got;
    t_res             r_res, n_res;
    t_res             r_hold, n_hold;
    logic             r_hold_v, n_hold_v;
    logic             r_found, n_found;
    logic             r_got_v, n_got_v;
    logic             r_best_v, n_best_v;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_hit, n_hit;
    logic [MC_W-1:0]  r_n, n_n;
    logic [MC_W-1:0]  r_mc, n_mc;
    logic [BKT_W-1:0] r_idx, n_idx;
    logic [BKT_W-1:0] r_best, n_best;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [LADDR_W-1:0] r_lrd, n_lrd;
    logic [LADDR_W-1:0] r_wrd, n_wrd;
    logic [BKT_W-1:0]   r_mrd, n_mrd;

    logic               l_we;
    logic [LADDR_W-1:0] l_wa;
    t_live              l_wdata;
    logic               w_we;
    logic [LADDR_W-1:0] w_wa;
    t_wait              w_wdata;
    logic               m_we;
    t_meta              m_wdata;

    t_meta            m_cur;
    logic             down;
    logic             at_end;
    logic [BKT_W-1:0] next_idx;
    logic             more_slots;

    assign m_cur      = r_mvld_rd ? r_meta_rd : '0;
    assign down       = r_cmd.bucket > BKT_W'(SPLIT_BKT);
    assign at_end     = down ? (r_idx == '0) : (r_idx == BKT_W'(LAST_BKT));
    assign next_idx   = down ? r_idx - 1'b1 : r_idx + 1'b1;
    assign more_slots = ((CNT_W+1)'(r_slot) + 1'b1) < (CNT_W+1)'(r_meta.fill);

    always_comb begin
        t_meta          mt;
        logic [CNT_W:0] hs;
        logic [CNT_W:0] wf;
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_meta   = r_meta;
        n_ent    = r_ent;
        n_got    = r_got;
        n_res    = r_res;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_found  = r_found;
        n_got_v  = r_got_v;
        n_best_v = r_best_v;
        n_slot   = r_slot;
        n_hit    = r_hit;
        n_n      = r_n;
        n_mc     = r_mc;
        n_idx    = r_idx;
        n_best   = r_best;
        n_total  = r_total;
        n_lrd    = r_lrd;
        n_wrd    = r_wrd;
        n_mrd    = r_mrd;
        l_we     = 1'b0;
        l_wa     = r_lrd;
        l_wdata  = r_live_rd;
        w_we     = 1'b0;
        w_wa     = r_wrd;
        w_wdata  = r_wait_rd;
        m_we     = 1'b0;
        m_wdata  = r_meta;
        o_cmd_pop = 1'b0;
        o_oq_push = 1'b0;
        o_oq_data = r_res;
        mt       = r_meta;
        hs       = '0;
        wf       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_found   = 1'b0;
                    case (i_cmd.op)
                        OP_UPDATE, OP_MARK_BAD: begin
                            n_mrd   = i_cmd.bucket;
                            n_state = S_META;
                        end
                        OP_FIND: begin
                            n_idx    = i_cmd.bucket;
                            n_mrd    = i_cmd.bucket;
                            n_n      = '0;
                            n_hold_v = 1'b0;
                            n_mc     = (i_cmd.mc > MC_W'(MAX_OUT)) ? MC_W'(MAX_OUT) : i_cmd.mc;
                            if (i_cmd.mc == '0) begin
                                n_res   = res_plain(ST_NONE, 1'b0);
                                n_state = S_OUT;
                            end else begin
                                n_state = S_FMETA;
                            end
                        end
                        OP_REFRESH: begin
                            n_idx    = '0;
                            n_mrd    = '0;
                            n_best_v = 1'b0;
                            n_state  = S_RSCAN;
                        end
                        OP_COUNT: begin
                            n_res       = res_plain(ST_COUNT, 1'b0);
                            n_res.total = r_total;
                            n_state     = S_OUT;
                        end
                        default: begin
                            n_res   = res_plain(ST_NONE, 1'b0);
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_META: begin
                n_meta = m_cur;
                if (m_cur.fill == '0) begin
                    n_state = S_DECIDE;
                end else begin
                    n_slot  = '0;
                    n_lrd   = slot_addr(r_cmd.bucket, '0);
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_live_rd.peer == r_cmd.peer) begin
                    n_found = 1'b1;
                    n_hit   = r_slot;
                    n_ent   = r_live_rd;
                    n_state = S_DECIDE;
                end else if (more_slots) begin
                    n_slot = r_slot + 1'b1;
                    n_lrd  = r_lrd + 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                case (r_cmd.op)
                    OP_UPDATE: begin
                        if (r_found) begin
                            l_we    = 1'b1;
                            l_wa    = slot_addr(r_cmd.bucket, r_hit);
                            l_wdata = r_ent;
                            l_wdata.seen = r_cmd.now;
                            l_wdata.questionable = 1'b0;
                            mt.touched = r_cmd.now;
                            m_we    = 1'b1;
                            n_res   = res_plain(ST_UPDATED, 1'b0);
                        end else if (r_meta.fill < CNT_W'(BUCKET_SIZE)) begin
                            l_we    = 1'b1;
                            l_wa    = slot_addr(r_cmd.bucket, r_meta.fill);
                            l_wdata.peer = r_cmd.peer;
                            l_wdata.seen = r_cmd.now;
                            l_wdata.questionable = 1'b0;
                            mt.fill    = r_meta.fill + 1'b1;
                            mt.touched = r_cmd.now;
                            m_we    = 1'b1;
                            n_total = r_total + 1'b1;
                            n_res   = res_plain(ST_ADDED, 1'b1);
                        end else begin
                            hs = (CNT_W+1)'(r_meta.head);
                            wf = (CNT_W+1)'(r_meta.wfill);
                            if (wf >= (CNT_W+1)'(BUCKET_SIZE)) begin
                                hs = (CNT_W+1)'(slot_wrap(hs + 1'b1));
                                wf = (CNT_W+1)'(BUCKET_SIZE - 1);
                            end
                            w_we    = 1'b1;
                            w_wa    = slot_addr(r_cmd.bucket, CNT_W'(slot_wrap(hs + wf)));
                            w_wdata.peer = r_cmd.peer;
                            w_wdata.seen = r_cmd.now;
                            mt.head  = hs[SLOT_W-1:0];
                            mt.wfill = CNT_W'(wf + 1'b1);
                            m_we    = 1'b1;
                            n_res   = res_plain(ST_PENDING, 1'b1);
                        end
                        m_wdata = mt;
                    end
                    OP_MARK_BAD: begin
                        if (!r_found) begin
                            n_res = res_plain(ST_NOT_FOUND, 1'b0);
                        end else if (!r_ent.questionable) begin
                            l_we    = 1'b1;
                            l_wa    = slot_addr(r_cmd.bucket, r_hit);
                            l_wdata = r_ent;
                            l_wdata.questionable = 1'b1;
                            n_res   = res_plain(ST_QUESTIONABLE, 1'b0);
                        end else if (((CNT_W+1)'(r_hit) + 1'b1) < (CNT_W+1)'(r_meta.fill)) begin
                            n_slot  = r_hit;
                            n_lrd   = slot_addr(r_cmd.bucket, r_hit) + 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DROP;
                        end
                    end
                    default: begin
                        n_res = res_plain(ST_NONE, 1'b0);
                    end
                endcase
            end
            S_SHIFT: begin
                l_we    = 1'b1;
                l_wa    = slot_addr(r_cmd.bucket, r_slot);
                l_wdata = r_live_rd;
                if (((CNT_W+1)'(r_slot) + 2'd2) < (CNT_W+1)'(r_meta.fill)) begin
                    n_slot = r_slot + 1'b1;
                    n_lrd  = r_lrd + 1'b1;
                end else begin
                    n_state = S_DROP;
                end
            end
            S_DROP: begin
                mt.fill = r_meta.fill - 1'b1;
                if (r_meta.wfill != '0) begin
                    n_meta  = mt;
                    n_wrd   = slot_addr(r_cmd.bucket, CNT_W'(r_meta.head));
                    n_state = S_PROM;
                end else begin
                    m_we    = 1'b1;
                    m_wdata = mt;
                    n_total = r_total - 1'b1;
                    n_res   = res_plain(ST_REMOVED, 1'b1);
                    n_state = S_OUT;
                end
            end
            S_PROM: begin
                l_we    = 1'b1;
                l_wa    = slot_addr(r_cmd.bucket, r_meta.fill);
                l_wdata.peer = r_wait_rd.peer;
                l_wdata.seen = r_wait_rd.seen;
                l_wdata.questionable = 1'b0;
                mt.fill  = r_meta.fill + 1'b1;
                mt.head  = slot_wrap((CNT_W+1)'(r_meta.head) + 1'b1);
                mt.wfill = r_meta.wfill - 1'b1;
                m_we    = 1'b1;
                m_wdata = mt;
                n_res   = res_plain(ST_REMOVED, 1'b1);
                n_state = S_OUT;
            end
            S_FMETA: begin
                n_meta = m_cur;
                if (m_cur.fill != '0) begin
                    n_slot  = '0;
                    n_lrd   = slot_addr(r_idx, '0);
                    n_state = S_FDATA;
                end else if (at_end) begin
                    n_state = S_FEND;
                end else begin
                    n_idx = next_idx;
                    n_mrd = next_idx;
                end
            end
            S_FDATA: begin
                if (!(r_hold_v && i_oq_full)) begin
                    if (r_hold_v) begin
                        o_oq_push = 1'b1;
                        o_oq_data = r_hold;
                    end
                    n_hold   = res_peer(r_live_rd.peer, 1'b0);
                    n_hold_v = 1'b1;
                    n_n      = r_n + 1'b1;
                    if ((r_n + 1'b1) == r_mc) begin
                        n_state = S_FEND;
                    end else if (more_slots) begin
                        n_slot = r_slot + 1'b1;
                        n_lrd  = r_lrd + 1'b1;
                    end else if (at_end) begin
                        n_state = S_FEND;
                    end else begin
                        n_idx   = next_idx;
                        n_mrd   = next_idx;
                        n_state = S_FMETA;
                    end
                end
            end
            S_FEND: begin
                if (r_hold_v) begin
                    n_res      = r_hold;
                    n_res.last = 1'b1;
                end else begin
                    n_res = res_plain(ST_NONE, 1'b0);
                end
                n_state = S_OUT;
            end
            S_RSCAN: begin
                if (m_cur.fill != '0 && (!r_best_v || m_cur.touched > r_meta.touched)) begin
                    n_best   = r_idx;
                    n_best_v = 1'b1;
                    n_meta   = m_cur;
                end
                if (r_idx == BKT_W'(LAST_BKT)) begin
                    n_state = S_RSEL;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_mrd = r_idx + 1'b1;
                end
            end
            S_RSEL: begin
                if (!r_best_v) begin
                    n_res   = res_plain(ST_NONE, 1'b0);
                    n_state = S_OUT;
                end else begin
                    n_slot  = '0;
                    n_got_v = 1'b0;
                    n_lrd   = slot_addr(r_best, '0);
                    n_state = S_RSRCH;
                end
            end
            S_RSRCH: begin
                if (r_live_rd.questionable) begin
                    n_got   = r_live_rd;
                    n_state = S_RDONE;
                end else begin
                    if (!r_got_v || r_got.seen > r_live_rd.seen) begin
                        n_got   = r_live_rd;
                        n_got_v = 1'b1;
                    end
                    if (more_slots) begin
                        n_slot = r_slot + 1'b1;
                        n_lrd  = r_lrd + 1'b1;
                    end else begin
                        n_state = S_RDONE;
                    end
                end
            end
            S_RDONE: begin
                n_res   = res_peer(r_got.peer, 1'b1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_oq_full) begin
                    o_oq_push = 1'b1;
                    o_oq_data = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_hold_v   <= 1'b0;
            r_found    <= 1'b0;
            r_got_v    <= 1'b0;
            r_best_v   <= 1'b0;
            r_meta_vld <= '0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_hold_v <= n_hold_v;
            r_found  <= n_found;
            r_got_v  <= n_got_v;
            r_best_v <= n_best_v;
            if (m_we) r_meta_vld[r_cmd.bucket] <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_meta <= n_meta;
        r_ent  <= n_ent;
        r_got  <= n_got;
        r_res  <= n_res;
        r_hold <= n_hold;
        r_slot <= n_slot;
        r_hit  <= n_hit;
        r_n    <= n_n;
        r_mc   <= n_mc;
        r_idx  <= n_idx;
        r_best <= n_best;
        r_lrd  <= n_lrd;
        r_wrd  <= n_wrd;
        r_mrd  <= n_mrd;
    end

    // live list memory
    always_ff @(posedge i_clk) begin
        if (l_we) r_live_mem[l_wa] <= l_wdata;
        r_live_rd <= r_live_mem[n_lrd];
    end

    // pending ring memory
    always_ff @(posedge i_clk) begin
        if (w_we) r_wait_mem[w_wa] <= w_wdata;
        r_wait_rd <= r_wait_mem[n_wrd];
    end

    // bucket metadata memory
    always_ff @(posedge i_clk) begin
        if (m_we) r_meta_mem[r_cmd.bucket] <= m_wdata;
        r_meta_rd <= r_meta_mem[n_mrd];
        r_mvld_rd <= r_meta_vld[n_mrd];
    end

endmodule

>>> design/kbrt_outq.sv
module kbrt_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kbrt_pkg::t_res i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output kbrt_pkg::t_res o_head
);
    import kbrt_pkg::*;

    t_res                r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr;
    logic [OQ_PTR_W-1:0] r_rd;
    logic [OQ_PTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (OQ_PTR_W+1)'(OQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

>>> dv/tb_kbucket_routing_table.sv
`timescale 1ns / 1ps

module tb_kbucket_routing_table;
    import kbrt_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [2:0]   op;
        logic [159:0] id;
        logic [31:0]  address;
        logic [15:0]  port;
        logic [6:0]   mc;
        logic [47:0]  now;
    } t_req;

    typedef struct {
        t_req    req;
        logic    typed;
        t_status status;
        logic    changed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full, empty;
    logic pop = 1'b0;
    logic [2:0]  i_operation = '0;
    logic [31:0] i_peer_id_high = '0;
    logic [63:0] i_peer_id_mid = '0;
    logic [63:0] i_peer_id_low = '0;
    logic [31:0] i_peer_address = '0;
    logic [15:0] i_peer_port = '0;
    logic [6:0]  i_max_count = '0;
    logic [47:0] i_now = '0;
    logic [3:0]  o_status;
    logic [31:0] o_out_id_high;
    logic [63:0] o_out_id_mid;
    logic [63:0] o_out_id_low;
    logic [31:0] o_out_address;
    logic [15:0] o_out_port;
    logic [10:0] o_total_peers;
    logic        o_changed, o_last;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    kbucket_routing_table i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the table
    logic [159:0] own_id = '0;
    t_peer        live_peer [NUM_SLOTS];
    logic [47:0]  live_seen [NUM_SLOTS];
    logic         live_doubt [NUM_SLOTS];
    int           live_count [NUM_BUCKETS];
    logic [47:0]  touched [NUM_BUCKETS];
    t_peer        wait_peer [NUM_SLOTS];
    logic [47:0]  wait_seen [NUM_SLOTS];
    int           wait_head [NUM_BUCKETS];
    int           wait_count [NUM_BUCKETS];

    t_res route_answers[$];
    int   mismatches = 0;
    int   cycles = 0;
    logic steady = 1'b0;

    function automatic t_peer peer_of(t_req r);
        t_peer p;
        p.id_high = r.id[159:128];
        p.id_mid  = r.id[127:64];
        p.id_low  = r.id[63:0];
        p.address = r.address;
        p.port    = r.port;
        return p;
    endfunction

    function automatic int bucket_for(logic [159:0] id);
        logic [159:0] x;
        int b;
        x = id ^ own_id;
        b = 0;
        for (int i = 0; i < 160; i++) begin
            if (x[i]) b = i;
        end
        return b;
    endfunction

    function automatic t_res answer(t_status st, logic chg);
        t_res r;
        r = '0;
        r.status  = st;
        r.changed = chg;
        r.last    = 1'b1;
        return r;
    endfunction

    function automatic void route_table_step(input t_req r, ref t_res outs[$]);
        t_peer p;
        t_res  a;
        int b, base, fill, hit, w, n, idx, stp, lim, best, got;
        logic [10:0] total;
        p = peer_of(r);
        b = bucket_for(r.id);
        base = b * BUCKET_SIZE;
        fill = live_count[b];
        hit = -1;
        outs.delete();
        if (r.op == OP_UPDATE || r.op == OP_MARK_BAD) begin
            for (int s = 0; s < fill; s++) begin
                if (hit < 0 && live_peer[base+s] == p) hit = s;
            end
        end
        case (r.op)
            OP_UPDATE: begin
                if (hit < 0 && fill >= BUCKET_SIZE) begin
                    if (wait_count[b] >= BUCKET_SIZE) begin
                        wait_head[b] = (wait_head[b] + 1) % BUCKET_SIZE;
                        wait_count[b] = BUCKET_SIZE - 1;
                    end
                    w = base + (wait_head[b] + wait_count[b]) % BUCKET_SIZE;
                    wait_peer[w] = p;
                    wait_seen[w] = r.now;
                    wait_count[b]++;
                    outs.insert(outs.size(), answer(ST_PENDING, 1'b1));
                end else begin
                    touched[b] = r.now;
                    if (hit >= 0) begin
                        live_seen[base+hit] = r.now;
                        live_doubt[base+hit] = 1'b0;
                        outs.insert(outs.size(), answer(ST_UPDATED, 1'b0));
                    end else begin
                        live_peer[base+fill] = p;
                        live_seen[base+fill] = r.now;
                        live_doubt[base+fill] = 1'b0;
                        live_count[b] = fill + 1;
                        outs.insert(outs.size(), answer(ST_ADDED, 1'b1));
                    end
                end
            end
            OP_MARK_BAD: begin
                if (hit < 0) begin
                    outs.insert(outs.size(), answer(ST_NOT_FOUND, 1'b0));
                end else if (!live_doubt[base+hit]) begin
                    live_doubt[base+hit] = 1'b1;
                    outs.insert(outs.size(), answer(ST_QUESTIONABLE, 1'b0));
                end else begin
                    for (int s = hit; s + 1 < fill; s++) begin
                        live_peer[base+s]  = live_peer[base+s+1];
                        live_seen[base+s]  = live_seen[base+s+1];
                        live_doubt[base+s] = live_doubt[base+s+1];
                    end
                    fill--;
                    if (wait_count[b] > 0) begin
                        live_peer[base+fill]  = wait_peer[base+wait_head[b]];
                        live_seen[base+fill]  = wait_seen[base+wait_head[b]];
                        live_doubt[base+fill] = 1'b0;
                        fill++;
                        wait_head[b] = (wait_head[b] + 1) % BUCKET_SIZE;
                        wait_count[b]--;
                    end
                    live_count[b] = fill;
                    outs.insert(outs.size(), answer(ST_REMOVED, 1'b1));
                end
            end
            OP_FIND: begin
                n = 0;
                idx = b;
                stp = (b > SPLIT_BKT) ? -1 : 1;
                lim = (r.mc > MAX_OUT) ? MAX_OUT : int'(r.mc);
                while (n < lim) begin
                    for (int s = 0; s < live_count[idx] && n < lim; s++) begin
                        a = answer(ST_PEER, 1'b0);
                        a.peer = live_peer[idx*BUCKET_SIZE+s];
                        a.last = 1'b0;
                        outs.insert(outs.size(), a);
                        n++;
                    end
                    idx += stp;
                    if (idx < 0 || idx >= NUM_BUCKETS) break;
                end
                if (n == 0) outs.insert(outs.size(), answer(ST_NONE, 1'b0));
                else outs[n-1].last = 1'b1;
            end
            OP_REFRESH: begin
                best = -1;
                got = -1;
                for (int k = 0; k < NUM_BUCKETS; k++) begin
                    if (live_count[k] != 0 && (best < 0 || touched[k] > touched[best]))
                        best = k;
                end
                if (best < 0) begin
                    outs.insert(outs.size(), answer(ST_NONE, 1'b0));
                end else begin
                    for (int s = 0; s < live_count[best]; s++) begin
                        idx = best * BUCKET_SIZE + s;
                        if (live_doubt[idx]) begin
                            got = idx;
                            break;
                        end
                        if (got < 0 || live_seen[got] > live_seen[idx]) got = idx;
                    end
                    a = answer(ST_PEER, 1'b0);
                    a.peer = live_peer[got];
                    outs.insert(outs.size(), a);
                end
            end
            OP_COUNT: begin
                total = '0;
                for (int k = 0; k < NUM_BUCKETS; k++) total += 11'(live_count[k]);
                a = answer(ST_COUNT, 1'b0);
                a.total = total;
                outs.insert(outs.size(), a);
            end
            default: outs.insert(outs.size(), answer(ST_NONE, 1'b0));
        endcase
    endfunction

    // result side
    always @(posedge i_clk) begin
        t_res want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            if (i_rst_n && pop && !empty) begin
                if (route_answers.size() == 0) begin
                    $error("transaction with nothing expected, status %0d", o_status);
                    mismatches++;
                end else begin
                    want = route_answers[0];
                    route_answers.delete(0);
                    if (o_status != want.status) begin
                        $error("status exp %0d got %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_out_id_high != want.peer.id_high) begin
                        $error("out_id_high exp %h got %h", want.peer.id_high, o_out_id_high);
                        mismatches++;
                    end
                    if (o_out_id_mid != want.peer.id_mid) begin
                        $error("out_id_mid exp %h got %h", want.peer.id_mid, o_out_id_mid);
                        mismatches++;
                    end
                    if (o_out_id_low != want.peer.id_low) begin
                        $error("out_id_low exp %h got %h", want.peer.id_low, o_out_id_low);
                        mismatches++;
                    end
                    if (o_out_address != want.peer.address) begin
                        $error("out_address exp %h got %h", want.peer.address, o_out_address);
                        mismatches++;
                    end
                    if (o_out_port != want.peer.port) begin
                        $error("out_port exp %h got %h", want.peer.port, o_out_port);
                        mismatches++;
                    end
                    if (o_total_peers != want.total) begin
                        $error("total_peers exp %0d got %0d", want.total, o_total_peers);
                        mismatches++;
                    end
                    if (o_changed != want.changed) begin
                        $error("changed exp %0d got %0d", want.changed, o_changed);
                        mismatches++;
                    end
                    if (o_last != want.last) begin
                        $error("last exp %0d got %0d", want.last, o_last);
                        mismatches++;
                    end
                end
            end
            pop <= steady ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    task automatic send(input t_req r, output t_res got[$]);
        if (!steady && $urandom_range(99) < 35) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_operation    <= r.op;
        i_peer_id_high <= r.id[159:128];
        i_peer_id_mid  <= r.id[127:64];
        i_peer_id_low  <= r.id[63:0];
        i_peer_address <= r.address;
        i_peer_port    <= r.port;
        i_max_count    <= r.mc;
        i_now          <= r.now;
        do @(posedge i_clk); while (full);
        route_table_step(r, got);
    endtask

    task automatic send_checked(input t_req r);
        t_res got[$];
        send(r, got);
        foreach (got[i]) route_answers.insert(route_answers.size(), got[i]);
    endtask

    task automatic settle;
        push <= 1'b0;
        while (route_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index) * PADDR_W'(8);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_OWN_HIGH: own_id[159:128] = value[31:0];
            REG_OWN_MID:  own_id[127:64]  = value;
            default:      own_id[63:0]    = value;
        endcase
    endtask

    task automatic set_own(input logic [159:0] id);
        write_reg(REG_OWN_HIGH, {32'd0, id[159:128]});
        write_reg(REG_OWN_MID, id[127:64]);
        write_reg(REG_OWN_LOW, id[63:0]);
    endtask

    function automatic t_req mk(logic [2:0] op, logic [159:0] id, logic [31:0] adr,
                                logic [15:0] port, logic [6:0] mc, logic [47:0] now);
        t_req r;
        r.op = op;
        r.id = id;
        r.address = adr;
        r.port = port;
        r.mc = mc;
        r.now = now;
        return r;
    endfunction

    function automatic t_row row(t_req r, logic typed, t_status st, logic chg);
        t_row x;
        x.req = r;
        x.typed = typed;
        x.status = st;
        x.changed = chg;
        return x;
    endfunction

    function automatic logic [159:0] rand_id();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    // peers clustered in a few buckets so lists fill and pending rings wrap
    t_req peer_pool[40];

    task automatic make_pool;
        int hot[4];
        int b;
        logic [159:0] mask;
        hot[0] = $urandom_range(0, 3);
        hot[1] = $urandom_range(79, 82);
        hot[2] = 159;
        hot[3] = $urandom_range(4, 158);
        foreach (peer_pool[i]) begin
            b = ($urandom_range(99) < 85) ? hot[$urandom_range(0, 3)] : $urandom_range(0, 159);
            mask = (160'd1 << b) - 160'd1;
            peer_pool[i].id = own_id ^ (160'd1 << b) ^ (rand_id() & mask);
            if ($urandom_range(9) == 0) peer_pool[i].id = own_id;
            peer_pool[i].address = ($urandom_range(1) != 0) ? $urandom : 32'(i);
            peer_pool[i].port = 16'($urandom_range(0, 3)) << 14;
        end
    endtask

    logic [47:0] clock_ticks = '0;

    task automatic random_phase(input int count);
        t_req r;
        int pick, sel;
        make_pool();
        for (int k = 0; k < count; k++) begin
            if (k == count / 2) begin
                push <= 1'b0;
                while (route_answers.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 39);
            r = peer_pool[pick];
            clock_ticks += 48'($urandom_range(0, 1000));
            r.now = ($urandom_range(9) == 0) ? {$urandom, $urandom} : clock_ticks;
            r.mc = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12));
            sel = $urandom_range(99);
            if (sel < 48) begin
                r.op = OP_UPDATE;
                if ($urandom_range(4) == 0) begin
                    r.id = rand_id();
                    r.address = $urandom;
                    r.port = 16'($urandom);
                end
            end else if (sel < 70) r.op = OP_MARK_BAD;
            else if (sel < 82) begin
                r.op = OP_FIND;
                if ($urandom_range(2) == 0) r.id = rand_id();
            end else if (sel < 90) r.op = OP_REFRESH;
            else if (sel < 96) r.op = OP_COUNT;
            else r.op = ($urandom_range(1) != 0) ? OP_SPARE_LO : 3'($urandom_range(5, 7));
            send_checked(r);
        end
        settle();
    endtask

    initial begin
        t_row plan[$];
        t_res got[$];
        t_res typed_answer;
        logic [159:0] ones;
        ones = '1;
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            live_count[b] = 0;
            touched[b] = '0;
            wait_head[b] = 0;
            wait_count[b] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.insert(plan.size(), row(mk(OP_COUNT, '0, '0, '0, '0, '0), 1'b1, ST_COUNT, 1'b0));
        plan.insert(plan.size(), row(mk(OP_FIND, ones, '0, '0, 7'd5, '0), 1'b1, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_REFRESH, '0, '0, '0, '0, '0), 1'b1, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_MARK_BAD, 160'd1, '1, '1, '0, '0), 1'b1,
                                     ST_NOT_FOUND, 1'b0));
        plan.insert(plan.size(), row(mk(OP_SPARE_LO, '0, '0, '0, '0, '0), 1'b1, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_SPARE_HI, ones, '1, '1, '1, '1), 1'b1,
                                     ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_UPDATE, '0, '0, '0, '0, '0), 1'b1, ST_ADDED, 1'b1));
        plan.insert(plan.size(), row(mk(OP_UPDATE, '0, '0, '0, '0, '1), 1'b1,
                                     ST_UPDATED, 1'b0));
        for (int k = 0; k < 10; k++)
            plan.insert(plan.size(), row(mk(OP_UPDATE, ones ^ 160'(k), '1, '1, '0,
                                            48'(100 - k)), 1'b0, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_MARK_BAD, ones, '1, '1, '0, '0), 1'b1,
                                     ST_QUESTIONABLE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_MARK_BAD, ones, '1, '1, '0, '0), 1'b1,
                                     ST_REMOVED, 1'b1));
        plan.insert(plan.size(), row(mk(OP_REFRESH, '0, '0, '0, '0, '0), 1'b0, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_FIND, ones, '0, '0, 7'd127, '0), 1'b0,
                                     ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_FIND, ones, '0, '0, 7'd0, '0), 1'b1, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_FIND, '0, '0, '0, 7'd64, '0), 1'b0, ST_NONE, 1'b0));
        plan.insert(plan.size(), row(mk(OP_COUNT, '0, '0, '0, '0, '0), 1'b0, ST_NONE, 1'b0));

        foreach (plan[i]) begin
            send(plan[i].req, got);
            if (plan[i].typed) begin
                typed_answer = answer(plan[i].status, plan[i].changed);
                route_answers.insert(route_answers.size(), typed_answer);
            end else begin
                foreach (got[j]) route_answers.insert(route_answers.size(), got[j]);
            end
        end
        settle();

        set_own(ones);
        random_phase(150);
        steady = 1'b1;
        set_own(rand_id());
        random_phase(80);
        steady = 1'b0;
        random_phase(80);
        set_own('0);
        random_phase(150);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
